### rtl/core/hlm_pkg.sv
// Shared types, constants and font table of the hex LED matrix scanner.
`default_nettype none

package hlm_pkg;

  localparam int NUM_COLUMNS = 10;
  localparam int DIGIT_COLS  = 5;
  localparam int ROW_W       = 7;
  localparam int GROUP_W     = 5;
  localparam int COL_W       = 4;
  localparam int HEX_W       = 8;
  localparam int NIBBLE_W    = 4;
  localparam int FCOL_W      = 3;

  localparam logic [COL_W-1:0]   COLUMN_RESET = COL_W'(NUM_COLUMNS - 1);
  localparam logic [GROUP_W-1:0] GROUP_OFF    = {GROUP_W{1'b1}};

  // Item kinds on the input channel
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef logic [ROW_W-1:0] row_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row_bits;
    logic [GROUP_W-1:0] low_group_select_n;
    logic [GROUP_W-1:0] high_group_select_n;
    logic               frame_done;
    logic               accepted;
  } hlm_result_t;

  // One font column of a hex digit; column 0 is the leftmost
  function automatic row_t glyph_column(logic [NIBBLE_W-1:0] digit,
                                        logic [FCOL_W-1:0] col);
    logic [DIGIT_COLS*ROW_W-1:0] cols;
    row_t                        res;
    case (digit)
      4'h0:    cols = {7'h3E, 7'h45, 7'h49, 7'h51, 7'h3E};
      4'h1:    cols = {7'h00, 7'h21, 7'h7F, 7'h01, 7'h00};
      4'h2:    cols = {7'h21, 7'h43, 7'h45, 7'h49, 7'h31};
      4'h3:    cols = {7'h42, 7'h41, 7'h51, 7'h69, 7'h46};
      4'h4:    cols = {7'h0C, 7'h14, 7'h24, 7'h7F, 7'h04};
      4'h5:    cols = {7'h72, 7'h51, 7'h51, 7'h51, 7'h4E};
      4'h6:    cols = {7'h1E, 7'h29, 7'h49, 7'h49, 7'h06};
      4'h7:    cols = {7'h40, 7'h47, 7'h48, 7'h50, 7'h60};
      4'h8:    cols = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
      4'h9:    cols = {7'h30, 7'h49, 7'h49, 7'h4A, 7'h3C};
      4'hA:    cols = {7'h3F, 7'h44, 7'h44, 7'h44, 7'h3F};
      4'hB:    cols = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h36};
      4'hC:    cols = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h22};
      4'hD:    cols = {7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C};
      4'hE:    cols = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h41};
      default: cols = {7'h7F, 7'h48, 7'h48, 7'h48, 7'h40};
    endcase
    case (col)
      3'd0:    res = cols[34:28];
      3'd1:    res = cols[27:21];
      3'd2:    res = cols[20:14];
      3'd3:    res = cols[13:7];
      3'd4:    res = cols[6:0];
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/core/hlm_if.sv
// Channel interfaces of the hex LED matrix scanner: input items and result items.
`default_nettype none

interface hlm_in_if;
  import hlm_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [HEX_W-1:0] hex_value;

  modport source (output valid, output mode, output hex_value, input ready);
  modport sink   (input valid, input mode, input hex_value, output ready);
endinterface

interface hlm_out_if;
  import hlm_pkg::*;
  logic               valid;
  logic               ready;
  logic [ROW_W-1:0]   row_bits;
  logic [GROUP_W-1:0] low_group_select_n;
  logic [GROUP_W-1:0] high_group_select_n;
  logic               frame_done;
  logic               accepted;

  modport source (output valid, output row_bits, output low_group_select_n,
                  output high_group_select_n, output frame_done, output accepted,
                  input ready);
  modport sink   (input valid, input row_bits, input low_group_select_n,
                  input high_group_select_n, input frame_done, input accepted,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/hlm_scan_core.sv
// Column counter, frame flag and column buffer with the per-beat result logic.
`default_nettype none

module hlm_scan_core
  import hlm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic             mode,
  input  wire logic [HEX_W-1:0] hex_value,
  output hlm_result_t           result
);

  logic [COL_W-1:0]  column_index_r, column_index_nxt;
  logic              frame_ready_r, frame_ready_nxt;
  row_t              column_buffer_r   [NUM_COLUMNS];
  row_t              column_buffer_nxt [NUM_COLUMNS];
  logic [COL_W-1:0]  rd_idx;
  logic [FCOL_W-1:0] hi_pos;

  assign rd_idx = COL_W'(NUM_COLUMNS - 1) - column_index_r;
  assign hi_pos = FCOL_W'(column_index_r - COL_W'(DIGIT_COLS));

  always_comb begin
    column_index_nxt  = column_index_r;
    frame_ready_nxt   = frame_ready_r;
    column_buffer_nxt = column_buffer_r;
    result.row_bits            = '0;
    result.low_group_select_n  = GROUP_OFF;
    result.high_group_select_n = GROUP_OFF;
    result.frame_done          = 1'b0;
    result.accepted            = 1'b0;

    if (mode == MODE_WRITE) begin
      // load both digits only once the last frame has been shown
      if (frame_ready_r) begin
        for (int i = 0; i < DIGIT_COLS; i++) begin
          column_buffer_nxt[i] =
            glyph_column(hex_value[HEX_W-1:NIBBLE_W], FCOL_W'(i));
          column_buffer_nxt[DIGIT_COLS + i] =
            glyph_column(hex_value[NIBBLE_W-1:0], FCOL_W'(i));
        end
        frame_ready_nxt = 1'b0;
        result.accepted = 1'b1;
      end
    end else begin
      if (column_index_r < COL_W'(NUM_COLUMNS)) begin
        result.row_bits = column_buffer_r[rd_idx];
        if (column_index_r < COL_W'(DIGIT_COLS)) begin
          result.low_group_select_n =
            ~(GROUP_W'(1) << column_index_r[FCOL_W-1:0]);
        end else begin
          result.high_group_select_n = ~(GROUP_W'(1) << hi_pos);
        end
      end
      // advance; wrap marks end of frame
      if (column_index_r >= COL_W'(NUM_COLUMNS - 1)) begin
        column_index_nxt  = '0;
        frame_ready_nxt   = 1'b1;
        result.frame_done = 1'b1;
      end else begin
        column_index_nxt = column_index_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_index_r <= COLUMN_RESET;
      frame_ready_r  <= 1'b0;
      for (int i = 0; i < NUM_COLUMNS; i++) begin
        column_buffer_r[i] <= '0;
      end
    end else if (push) begin
      column_index_r  <= column_index_nxt;
      frame_ready_r   <= frame_ready_nxt;
      column_buffer_r <= column_buffer_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/hlm_out_buf.sv
// Two-entry result register with skid stage between core and result channel.
`default_nettype none

module hlm_out_buf
  import hlm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire hlm_result_t push_data,
  output logic             can_push,
  output logic             out_valid,
  input  wire logic        out_ready,
  output hlm_result_t      out_data
);

  logic        main_valid_r, main_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  hlm_result_t main_r, main_nxt;
  hlm_result_t skid_r, skid_nxt;
  logic        main_free;

  assign can_push  = !skid_valid_r;
  assign main_free = !main_valid_r || out_ready;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (main_free) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_nxt       = push_data;
        main_valid_nxt = push;
      end
    end else if (push) begin
      // hold the stalled beat, park the new one
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/hex_led_matrix_scanner.sv
// Top level of the hex LED matrix scanner: scan core plus result skid buffer.
// A result beat is registered in the result buffer before it appears on the result channel.
// Throughput: one input beat per cycle; the two-entry result buffer lets input flow on
//   for one beat while the result side stalls, then holds input ready low.
// Reset (rst_n low, synchronous): column counter to 9, column buffer blank,
//   frame flag clear, result buffer empty.
`default_nettype none

module hex_led_matrix_scanner
  import hlm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  hlm_in_if.sink     in_ch,
  hlm_out_if.source  out_ch
);

  logic        push;
  logic        can_push;
  hlm_result_t core_result;
  hlm_result_t out_data;

  // Take an input beat whenever the skid stage is empty; state moves on the same edge.
  assign in_ch.ready = can_push;
  assign push        = in_ch.valid && can_push;

  // Counter, frame flag and font buffer; the result is pure logic on the current state and input beat.
  hlm_scan_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .mode      (in_ch.mode),
    .hex_value (in_ch.hex_value),
    .result    (core_result)
  );

  // Register the result; park one more beat when the sink stalls.
  hlm_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (core_result),
    .can_push  (can_push),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  // Unpack the result beat onto the channel.
  assign out_ch.row_bits            = out_data.row_bits;
  assign out_ch.low_group_select_n  = out_data.low_group_select_n;
  assign out_ch.high_group_select_n = out_data.high_group_select_n;
  assign out_ch.frame_done          = out_data.frame_done;
  assign out_ch.accepted            = out_data.accepted;

  // At most one column is ever selected across both groups.
  a_one_select: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ($countones(~{out_ch.low_group_select_n,
                                   out_ch.high_group_select_n}) <= 1))
    else $error("more than one column select active");

  // A loaded write drives nothing onto the matrix.
  a_write_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.accepted) |->
      (out_ch.row_bits == '0 && out_ch.low_group_select_n == GROUP_OFF &&
       out_ch.high_group_select_n == GROUP_OFF && !out_ch.frame_done))
    else $error("write beat carries scan data");

  // The frame only ends on the last column, which sits in the high group.
  a_wrap_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frame_done) |->
      (out_ch.high_group_select_n == ~(GROUP_W'(1) << (GROUP_W - 1)) &&
       out_ch.low_group_select_n == GROUP_OFF))
    else $error("frame end outside last column");

  // A beat taken while the result side stalls lands in the skid stage, which drops
  // input ready on the next cycle.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_ch.valid && !out_ch.ready) |=> !in_ch.ready)
    else $error("skid stage not holding stalled beat");

endmodule

`default_nettype wire
